[rtl/core/tsdf_pkg.sv]
// Shared types and constants for the torus distance and gradient pipeline.
package tsdf_pkg;

    localparam int COORD_W = 32;
    localparam int GRAD_W  = 18;
    localparam int REG_W   = 31;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam int SQ1_IW = 64;
    localparam int SQ1_OW = 32;
    localparam int SQ2_IW = 66;
    localparam int SQ2_OW = 33;

    localparam logic [REG_W-1:0] MAJOR_RST = 31'd65536;
    localparam logic [REG_W-1:0] MINOR_RST = 31'd16384;

    typedef enum logic {
        REG_MAJOR = 1'b0,
        REG_MINOR = 1'b1
    } t_reg_idx;

    // Coordinate magnitudes and signs of one point
    typedef struct packed {
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        logic [COORD_W-1:0] az;
        logic               sx;
        logic               sy;
        logic               sz;
    } t_pt;

    // Data carried alongside the second root
    typedef struct packed {
        logic [COORD_W-1:0] aq;
        logic               qneg;
        logic [COORD_W-1:0] az;
        logic               sx;
        logic               sy;
        logic               sz;
    } t_geo;

endpackage

[rtl/core/tsdf_delay.sv]
// Enabled shift line that keeps side data aligned with the pipelined units.
module tsdf_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_pipe [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe[0] <= i_d;
            for (int s = 1; s < DEPTH; s++) begin
                r_pipe[s] <= r_pipe[s-1];
            end
        end
    end

    assign o_q = r_pipe[DEPTH-1];

endmodule

[rtl/core/tsdf_sqrt.sv]
// Pipelined integer square root, one result bit per stage, truncated down.
module tsdf_sqrt #(
    parameter int IW = 64
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [IW-1:0]       i_v,
    output logic [IW/2-1:0]     o_root
);

    localparam int OW = IW / 2;
    localparam int TW = IW + 1;

    logic [IW-1:0] r_rem  [OW-1];
    logic [OW-1:0] r_root [OW];

    for (genvar s = 0; s < OW; s++) begin : g_stage
        localparam int K = OW - 1 - s;
        logic [IW-1:0] cur_rem;
        logic [OW-1:0] cur_root;
        logic [TW-1:0] trial;
        logic          take;

        if (s == 0) begin : g_first
            assign cur_rem  = i_v;
            assign cur_root = '0;
        end else begin : g_next
            assign cur_rem  = r_rem[s-1];
            assign cur_root = r_root[s-1];
        end

        // (R + 2^k)^2 - R^2 = R*2^(k+1) + 2^(2k)
        assign trial = (TW'(cur_root) << (K + 1)) | (TW'(1) << (2 * K));
        assign take  = TW'(cur_rem) >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[s] <= take ? (cur_root | (OW'(1) << K)) : cur_root;
            end
        end

        if (s < OW - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= take ? IW'(TW'(cur_rem) - trial) : cur_rem;
                end
            end
        end
    end

    assign o_root = r_root[OW-1];

endmodule

[rtl/core/tsdf_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module tsdf_div #(
    parameter int NW = 48,
    parameter int DW = 32,
    parameter int QW = 17
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo,
    output logic          o_ovf
);

    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic [CW-1:0] r_rem [QW-1];
    logic [DW-1:0] r_den [QW-1];
    logic [QW-1:0] r_quo [QW];
    logic          r_ovf [QW];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        localparam int K = QW - 1 - s;
        logic [CW-1:0] cur_rem;
        logic [DW-1:0] cur_den;
        logic [QW-1:0] cur_quo;
        logic          cur_ovf;
        logic [CW-1:0] trial;
        logic          take;

        if (s == 0) begin : g_first
            assign cur_rem = CW'(i_num);
            assign cur_den = i_den;
            assign cur_quo = '0;
            // quotient does not fit in QW bits (also a zero divisor)
            assign cur_ovf = CW'(i_num >> QW) >= CW'(i_den);
        end else begin : g_next
            assign cur_rem = r_rem[s-1];
            assign cur_den = r_den[s-1];
            assign cur_quo = r_quo[s-1];
            assign cur_ovf = r_ovf[s-1];
        end

        assign trial = CW'(cur_den) << K;
        assign take  = cur_rem >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[s] <= take ? (cur_quo | (QW'(1) << K)) : cur_quo;
                r_ovf[s] <= cur_ovf;
            end
        end

        if (s < QW - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= take ? (cur_rem - trial) : cur_rem;
                    r_den[s] <= cur_den;
                end
            end
        end
    end

    assign o_quo = r_quo[QW-1];
    assign o_ovf = r_ovf[QW-1];

endmodule

[rtl/core/torus_sdf_distance_gradient.sv]
// Torus signed distance and gradient, fully pipelined, one point per cycle unless the result stalls.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+------------------------------------------
//  point   | in        | i_valid / o_stall | i_point_x, i_point_y, i_point_z
//  result  | out       | o_valid / i_stall | o_signed_distance, o_gradient_x/y/z
//  config  | in        | APB psel/penable  | paddr, pwdata, prdata, pready
//
//  One point per cycle while the result is not stalled; the depth is set by the two bit-serial
//  root pipelines (32 and 33 stages) and the FRAC_BITS+1 stage dividers.
//  Reset (synchronous, active low) clears all valid bits and loads the radii.
//  A stalled result freezes the whole pipeline in place; nothing is lost or repeated.
module torus_sdf_distance_gradient import tsdf_pkg::*; #(
    parameter int FRAC_BITS   = 16,
    parameter int MIN_DIVISOR = 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [COORD_W-1:0] i_point_x,
    input  logic signed [COORD_W-1:0] i_point_y,
    input  logic signed [COORD_W-1:0] i_point_z,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [COORD_W-1:0] o_signed_distance,
    output logic signed [GRAD_W-1:0]  o_gradient_x,
    output logic signed [GRAD_W-1:0]  o_gradient_y,
    output logic signed [GRAD_W-1:0]  o_gradient_z,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready
);

    localparam int QW     = FRAC_BITS + 1;
    localparam int NGW    = COORD_W + FRAC_BITS;
    localparam int NFW    = COORD_W + 1 + FRAC_BITS;
    localparam int GQ_DLY = SQ2_OW + 3 - QW;
    localparam int LAT    = 3 + SQ1_OW + 3 + SQ2_OW + 1 + QW + 1;
    localparam logic [QW-1:0]     LIM   = QW'(1) << FRAC_BITS;
    localparam logic [SQ2_OW-1:0] MIN_D = SQ2_OW'(MIN_DIVISOR);

    // ---------------- configuration ----------------
    logic [REG_W-1:0] r_major;
    logic [REG_W-1:0] r_minor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_major <= MAJOR_RST;
            r_minor <= MINOR_RST;
        end else if (psel && penable && pwrite) begin
            unique case (t_reg_idx'(paddr[2]))
                REG_MAJOR: r_major <= pwdata[REG_W-1:0];
                REG_MINOR: r_minor <= pwdata[REG_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[2]))
            REG_MAJOR: prdata = {1'b0, r_major};
            REG_MINOR: prdata = {1'b0, r_minor};
        endcase
    end

    assign pready = 1'b1;

    // ---------------- flow control ----------------
    logic           en;
    logic [LAT-1:0] r_vld;

    assign en      = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // ---------------- p1..p3: magnitudes, squares, sum ----------------
    t_pt          r_pt1, r_pt2, r_pt3, pt_d;
    t_pt          n_pt1;
    logic [63:0]  r_sxx, r_syy, r_sum1;

    assign n_pt1.ax = i_point_x[COORD_W-1] ? COORD_W'(~i_point_x + 1'b1) : COORD_W'(i_point_x);
    assign n_pt1.ay = i_point_y[COORD_W-1] ? COORD_W'(~i_point_y + 1'b1) : COORD_W'(i_point_y);
    assign n_pt1.az = i_point_z[COORD_W-1] ? COORD_W'(~i_point_z + 1'b1) : COORD_W'(i_point_z);
    assign n_pt1.sx = i_point_x[COORD_W-1];
    assign n_pt1.sy = i_point_y[COORD_W-1];
    assign n_pt1.sz = i_point_z[COORD_W-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pt1  <= n_pt1;
            r_sxx  <= 64'(r_pt1.ax) * 64'(r_pt1.ax);
            r_syy  <= 64'(r_pt1.ay) * 64'(r_pt1.ay);
            r_pt2  <= r_pt1;
            r_sum1 <= r_sxx + r_syy;
            r_pt3  <= r_pt2;
        end
    end

    logic [SQ1_OW-1:0] lxy;

    tsdf_sqrt #(.IW(SQ1_IW)) u_sqrt_xy (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_v    (r_sum1),
        .o_root (lxy)
    );

    tsdf_delay #(.W($bits(t_pt)), .DEPTH(SQ1_OW)) u_dly_pt (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (r_pt3),
        .o_q   (pt_d)
    );

    // ---------------- in-plane unit vector ----------------
    logic [QW-1:0] gqx_raw, gqy_raw, gqx, gqy, gqx_d, gqy_d;
    logic          ovfx, ovfy;

    tsdf_div #(.NW(NGW), .DW(SQ1_OW), .QW(QW)) u_div_gqx (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num ({pt_d.ax, {FRAC_BITS{1'b0}}}),
        .i_den (lxy),
        .o_quo (gqx_raw),
        .o_ovf (ovfx)
    );

    tsdf_div #(.NW(NGW), .DW(SQ1_OW), .QW(QW)) u_div_gqy (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num ({pt_d.ay, {FRAC_BITS{1'b0}}}),
        .i_den (lxy),
        .o_quo (gqy_raw),
        .o_ovf (ovfy)
    );

    // overflow here only comes from a zero in-plane length (a point on the z axis): drop to zero
    assign gqx = ovfx ? '0 : gqx_raw;
    assign gqy = ovfy ? '0 : gqy_raw;

    tsdf_delay #(.W(2 * QW), .DEPTH(GQ_DLY)) u_dly_gq (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   ({gqx, gqy}),
        .o_q   ({gqx_d, gqy_d})
    );

    // ---------------- p4..p6: tube offset, squares, sum ----------------
    logic signed [SQ1_OW+1:0] n_q;
    t_geo                     n_geo4, r_geo4, r_geo5, r_geo6, geo_d;
    logic [63:0]              r_aqq, r_azz;
    logic [SQ2_IW-1:0]        r_sum2;

    assign n_q         = $signed({2'b00, lxy}) - $signed({3'b000, r_major});
    assign n_geo4.qneg = n_q[SQ1_OW+1];
    assign n_geo4.aq   = n_q[SQ1_OW+1] ? COORD_W'(-n_q) : COORD_W'(n_q);
    assign n_geo4.az   = pt_d.az;
    assign n_geo4.sx   = pt_d.sx;
    assign n_geo4.sy   = pt_d.sy;
    assign n_geo4.sz   = pt_d.sz;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_geo4 <= n_geo4;
            r_aqq  <= 64'(r_geo4.aq) * 64'(r_geo4.aq);
            r_azz  <= 64'(r_geo4.az) * 64'(r_geo4.az);
            r_geo5 <= r_geo4;
            r_sum2 <= SQ2_IW'(r_aqq) + SQ2_IW'(r_azz);
            r_geo6 <= r_geo5;
        end
    end

    logic [SQ2_OW-1:0] lqz;

    tsdf_sqrt #(.IW(SQ2_IW)) u_sqrt_qz (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_v    (r_sum2),
        .o_root (lqz)
    );

    tsdf_delay #(.W($bits(t_geo)), .DEPTH(SQ2_OW)) u_dly_geo (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (r_geo6),
        .o_q   (geo_d)
    );

    // ---------------- p7: numerators, divisor, distance ----------------
    logic signed [SQ2_OW+1:0] n_dsub;
    logic [COORD_W-1:0]       n_dist, r_dist7;
    logic [NFW-1:0]           r_numx, r_numy, r_numz;
    logic [SQ2_OW-1:0]        r_den;
    logic                     r_negx, r_negy, r_negz;

    assign n_dsub = $signed({2'b00, lqz}) - $signed({4'b0000, r_minor});
    // the low end cannot be passed, clamp the high end only
    assign n_dist = (!n_dsub[SQ2_OW+1] && (n_dsub[SQ2_OW:COORD_W-1] != '0)) ?
                    32'h7FFF_FFFF : n_dsub[COORD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_numx  <= NFW'(geo_d.aq) * NFW'(gqx_d);
            r_numy  <= NFW'(geo_d.aq) * NFW'(gqy_d);
            r_numz  <= NFW'({geo_d.az, {FRAC_BITS{1'b0}}});
            r_den   <= (lqz < MIN_D) ? MIN_D : lqz;
            r_dist7 <= n_dist;
            r_negx  <= geo_d.qneg ^ geo_d.sx;
            r_negy  <= geo_d.qneg ^ geo_d.sy;
            r_negz  <= geo_d.sz;
        end
    end

    // ---------------- final division ----------------
    logic [QW-1:0]      qx, qy, qz;
    logic               ox, oy, oz;
    logic [COORD_W-1:0] dist_d;
    logic               negx_d, negy_d, negz_d;

    tsdf_div #(.NW(NFW), .DW(SQ2_OW), .QW(QW)) u_div_x (
        .i_clk (i_clk), .i_en (en), .i_num (r_numx), .i_den (r_den),
        .o_quo (qx), .o_ovf (ox)
    );

    tsdf_div #(.NW(NFW), .DW(SQ2_OW), .QW(QW)) u_div_y (
        .i_clk (i_clk), .i_en (en), .i_num (r_numy), .i_den (r_den),
        .o_quo (qy), .o_ovf (oy)
    );

    tsdf_div #(.NW(NFW), .DW(SQ2_OW), .QW(QW)) u_div_z (
        .i_clk (i_clk), .i_en (en), .i_num (r_numz), .i_den (r_den),
        .o_quo (qz), .o_ovf (oz)
    );

    tsdf_delay #(.W(COORD_W + 3), .DEPTH(QW)) u_dly_out (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   ({r_dist7, r_negx, r_negy, r_negz}),
        .o_q   ({dist_d, negx_d, negy_d, negz_d})
    );

    // Clamp magnitude to one, apply sign, keep the port width
    function automatic logic [GRAD_W-1:0] f_grad(input logic [QW-1:0] q,
                                                 input logic ovf, input logic neg);
        logic [QW-1:0] m;
        logic [31:0]   v;
        m = (ovf || (q > LIM)) ? LIM : q;
        v = neg ? (32'd0 - 32'(m)) : 32'(m);
        return v[GRAD_W-1:0];
    endfunction

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (en) begin
            o_signed_distance <= dist_d;
            o_gradient_x      <= f_grad(qx, ox, negx_d);
            o_gradient_y      <= f_grad(qy, oy, negy_d);
            o_gradient_z      <= f_grad(qz, oz, negz_d);
        end
    end

endmodule

[verif/tb_top.sv]
// Testbench for the torus distance and gradient block: directed and random points checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
    import tsdf_pkg::*;

    localparam int FRAC = 16;
    localparam int LATENCY = 74 + FRAC;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [63:0] GRAD_LIM = 64'd1 << FRAC;

    typedef struct {
        logic [31:0] sdist;
        logic [17:0] gx;
        logic [17:0] gy;
        logic [17:0] gz;
    } t_result;

    class torus_scoreboard;
        t_result pending[$];
        logic [30:0] major_r = MAJOR_RST;
        logic [30:0] minor_r = MINOR_RST;
        int errors = 0;

        static function logic [63:0] isqrt(logic [65:0] v);
            logic [65:0] res;
            logic [65:0] bitv;
            res = 0;
            bitv = 66'd1 << 64;
            while (bitv > v) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (v >= res + bitv) begin
                    v = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res[63:0];
        endfunction

        static function logic [17:0] sat_grad(logic [63:0] m, bit neg);
            logic [63:0] r;
            r = (m > GRAD_LIM) ? GRAD_LIM : m;
            if (neg) r = -r;
            return r[17:0];
        endfunction

        function void note_point(logic signed [31:0] x, logic signed [31:0] y,
                                 logic signed [31:0] z);
            logic [63:0] ax, ay, az, lxy, aq, lqz, gqx, gqy, dvs;
            logic signed [65:0] q, dval;
            t_result r;
            ax = (x < 0) ? -64'(x) : 64'(x);
            ay = (y < 0) ? -64'(y) : 64'(y);
            az = (z < 0) ? -64'(z) : 64'(z);
            lxy = isqrt(66'(ax * ax) + 66'(ay * ay));
            q = $signed({2'b0, lxy}) - $signed({35'b0, major_r});
            aq = (q < 0) ? 64'(-q) : 64'(q);
            lqz = isqrt(66'(aq * aq) + 66'(az * az));
            dval = $signed({2'b0, lqz}) - $signed({35'b0, minor_r});
            if (dval > 66'sd2147483647) dval = 66'sd2147483647;
            if (dval < -66'sd2147483648) dval = -66'sd2147483648;
            gqx = 0;
            gqy = 0;
            if (lxy != 0) begin
                gqx = (ax << FRAC) / lxy;
                gqy = (ay << FRAC) / lxy;
            end
            dvs = (lqz < 1) ? 64'd1 : lqz;
            r.sdist = dval[31:0];
            r.gx = sat_grad((aq * gqx) / dvs, (q < 0) != (x < 0));
            r.gy = sat_grad((aq * gqy) / dvs, (q < 0) != (y < 0));
            r.gz = sat_grad((az << FRAC) / dvs, z < 0);
            pending.push_back(r);
        endfunction

        function void check_result(logic [31:0] d, logic [17:0] gx, logic [17:0] gy,
                                   logic [17:0] gz);
            t_result e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result dist=%h", $realtime, d);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (e.sdist !== d) begin
                $display("%0t: distance exp %h act %h", $realtime, e.sdist, d);
                errors++;
            end
            if (e.gx !== gx) begin
                $display("%0t: gradient_x exp %h act %h", $realtime, e.gx, gx);
                errors++;
            end
            if (e.gy !== gy) begin
                $display("%0t: gradient_y exp %h act %h", $realtime, e.gy, gy);
                errors++;
            end
            if (e.gz !== gz) begin
                $display("%0t: gradient_z exp %h act %h", $realtime, e.gz, gz);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic o_stall;
    logic signed [31:0] i_point_x = 0, i_point_y = 0, i_point_z = 0;
    logic o_valid;
    logic i_stall = 0;
    logic signed [31:0] o_signed_distance;
    logic signed [17:0] o_gradient_x, o_gradient_y, o_gradient_z;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [ADDR_W-1:0] paddr = 0;
    logic [DATA_W-1:0] pwdata = 0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    torus_scoreboard sb = new();
    int idle_pct = 38;
    bit hold_off = 0;
    int quiet_cycles = 0;

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    torus_sdf_distance_gradient i_dut (.*);

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) sb.note_point(i_point_x, i_point_y, i_point_z);
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_signed_distance, o_gradient_x, o_gradient_y, o_gradient_z);
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // receiver stall: random, or held for a long stretch
    always @(posedge i_clk) begin
        i_stall <= hold_off || ($urandom_range(99) < idle_pct);
    end

    task automatic write_reg(t_reg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1;
        pwrite <= 1;
        penable <= 0;
        paddr <= ADDR_W'(idx) << 2;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        sb.major_r = (idx == REG_MAJOR) ? val[30:0] : sb.major_r;
        sb.minor_r = (idx == REG_MINOR) ? val[30:0] : sb.minor_r;
    endtask

    // called at a rising edge; returns at the edge that accepts the item
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_point_x <= x;
        i_point_y <= y;
        i_point_z <= z;
        do @(posedge i_clk); while (o_stall);
        // hold valid high into the next item; caller lowers when done
    endtask

    task automatic drain();
        i_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(4))
            0: return $urandom();
            1: return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
            2: return 32'($signed($urandom_range(1024)) - 512);
            default: return 32'($signed($urandom_range(4 << 16)) - (2 << 16));
        endcase
    endfunction

    task automatic random_phase(int n);
        for (int k = 0; k < n; k++) begin
            logic [31:0] x, y, z;
            x = rand_coord();
            y = rand_coord();
            z = rand_coord();
            if ($urandom_range(19) == 0) begin
                x = 0;
                y = 0;
            end
            send_point(x, y, z);
        end
        drain();
    endtask

    initial begin
        logic [31:0] ext[4];
        ext = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        // directed: extremes, axis, tube circle
        for (int a = 0; a < 4; a++)
            for (int b = 0; b < 4; b++)
                send_point(ext[a], ext[b], ext[(a + b) % 4]);
        send_point(32'h10000, 0, 0);
        send_point(0, 32'hFFFF0000, 0);
        send_point(0, 0, 32'h30000);
        send_point(32'h8000, 0, 32'h100);
        send_point(0, 0, 0);
        drain();
        random_phase(300);
        write_reg(REG_MAJOR, 32'h7FFFFFFF);
        write_reg(REG_MINOR, 32'hFFFFFFFF);
        random_phase(200);
        write_reg(REG_MAJOR, 0);
        write_reg(REG_MINOR, 0);
        random_phase(200);
        write_reg(REG_MAJOR, 32'h00020000);
        write_reg(REG_MINOR, 32'h00008000);
        // long receiver hold-off while points keep coming
        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge i_clk);
                hold_off = 0;
            end
            random_phase(250);
        join
        idle_pct = 0;
        random_phase(200);
        idle_pct = 38;
        write_reg(REG_MAJOR, $urandom_range(32'h7FFFFFFF));
        write_reg(REG_MINOR, $urandom_range(32'h0003FFFF));
        random_phase(150);
        if (sb.errors == 0) $display("tb_top passed");
        else $display("tb_top failed");
        $finish;
    end
endmodule
